// File: sv/cre_pkg.sv
// ----------------------------------------------------------------------------
// cre_pkg: shared types and constants of the Catmull-Rom key evaluator
// Item structs for both channels, field widths, command and register codes.
// ----------------------------------------------------------------------------
package cre_pkg;

    localparam int COMP_W    = 24;   // one key component, signed Q7.16
    localparam int KEY_COMPS = 4;    // components per key, keys per blend
    localparam int IDX_W     = 4;
    localparam int SEG_W     = 4;
    localparam int FRAC_IN_W = 16;
    localparam int KCNT_W    = 5;
    localparam int CNT_W     = 4;
    localparam int MIN_KEYS  = 4;
    localparam int SEG_STEPS = 3;    // 15 - 3*4 < 4, so three subtractions suffice
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam int COMP_MAX = 8388607;
    localparam int COMP_MIN = -8388608;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_KEY_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ORIENT    = 1'b1;

    localparam logic [KCNT_W-1:0] KEY_COUNT_RST = 5'd4;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [KEY_COMPS-1:0] key_row_t;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_W-1:0]     key_index;
        logic signed [23:0]   key_c0;
        logic signed [23:0]   key_c1;
        logic signed [23:0]   key_c2;
        logic signed [23:0]   key_c3;
        logic [SEG_W-1:0]     segment;
        logic [FRAC_IN_W-1:0] frac_u;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] out_c0;
        logic signed [23:0] out_c1;
        logic signed [23:0] out_c2;
        logic signed [23:0] out_c3;
        logic               clipped;
    } out_item_t;

endpackage

// File: sv/cre_ram.sv
// ----------------------------------------------------------------------------
// cre_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module cre_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rd_data_reg <= mem_array[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

// File: sv/catmull_rom_key_evaluator.sv
// ----------------------------------------------------------------------------
// catmull_rom_key_evaluator: closed-loop uniform Catmull-Rom key evaluator
// Stores keyframes of four Q7.16 components and blends four neighboring
// keys with the Catmull-Rom basis, optionally with quaternion sign alignment.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_ channel as in_item_t. A load item (cmd low)
// writes one key into the key RAM in the cycle of its transfer and produces
// no result; loads can follow each other in every cycle. An evaluate item
// (cmd high) blends keys segment-1 .. segment+2 (wrapping over key_count)
// and produces one out_item_t transfer on the m_ channel.
// Steps of an evaluate: the four keys are read while u^2 and u^3 are formed,
// the dot products follow in quaternion mode, then the blend products; the
// multiply-accumulate pipeline drains and the output register is loaded.
// The result is presented on m_valid in the same cycle as s_ready returns.
// Each step is paced by the single shared multiplier, which handles one
// product per cycle. s_ready is low while an evaluate is in progress. The
// output register holds a finished result while the receiver stalls; new
// items are still taken, and a following evaluate waits in its last step
// until the register is free. Reset (aresetn low, synchronous) returns the
// sequencer to idle, drops m_valid and restores key_count to 4 and position
// mode. The key RAM is not cleared: keys must be loaded before they are used.
// Configuration is written over the APB-style port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module catmull_rom_key_evaluator
    import cre_pkg::*;
#(
    parameter int MAX_KEYS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input item channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW     = $clog2(MAX_KEYS);
    localparam int F      = FRAC_BITS;
    localparam int HW     = F + 3;          // doubled basis weights, signed
    localparam int HX     = F + 4;          // headroom while forming them
    localparam int MUL_W  = (F + 3 > COMP_W) ? F + 3 : COMP_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [CNT_W-1:0] PREP_LAST  = CNT_W'(KEY_COMPS);
    localparam logic [CNT_W-1:0] DOT_LAST   = CNT_W'(KEY_COMPS * (KEY_COMPS - 1) - 1);
    localparam logic [CNT_W-1:0] BLEND_LAST = CNT_W'(KEY_COMPS * KEY_COMPS - 1);
    localparam logic [CNT_W-1:0] WAIT_LAST  = CNT_W'(1);
    localparam logic [1:0]       SUB_LAST   = 2'(KEY_COMPS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DOT   = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KCNT_W-1:0]    key_count_reg, key_count_next;
    logic                 orient_reg, orient_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        key_count_next = key_count_reg;
        orient_next    = orient_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_KEY_COUNT: key_count_next = pwdata[KCNT_W-1:0];
                REG_ORIENT:    orient_next    = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_COUNT: prdata = PDATA_W'(key_count_reg);
            REG_ORIENT:    prdata = PDATA_W'(orient_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective loop length and the first key of the window
    // ------------------------------------------------------------------
    logic [KCNT_W-1:0] k_eff;
    logic [KCNT_W-1:0] seg_mod;
    logic [KCNT_W-1:0] idx_first;
    logic [KCNT_W-1:0] idx_reg, idx_next, idx_inc;

    // Out-of-range key counts are clamped into the supported range.
    always_comb begin
        if (key_count_reg < KCNT_W'(MIN_KEYS)) begin
            k_eff = KCNT_W'(MIN_KEYS);
        end else if (int'(key_count_reg) > MAX_KEYS) begin
            k_eff = KCNT_W'(MAX_KEYS);
        end else begin
            k_eff = key_count_reg;
        end
    end

    // The segment is at most 15 and the loop at least 4 keys long, so a few
    // conditional subtractions reduce it modulo the loop length.
    always_comb begin
        seg_mod = KCNT_W'(s_data.segment);
        for (int i = 0; i < SEG_STEPS; i++) begin
            if (seg_mod >= k_eff) begin
                seg_mod = seg_mod - k_eff;
            end
        end
        idx_first = (seg_mod == '0) ? k_eff - KCNT_W'(1) : seg_mod - KCNT_W'(1);
    end

    assign idx_inc = (idx_reg + KCNT_W'(1) == k_eff) ? '0 : idx_reg + KCNT_W'(1);

    // ------------------------------------------------------------------
    // Key RAM
    // ------------------------------------------------------------------
    logic             in_xfer;
    logic             ram_we;
    key_row_t         ram_wdata;
    logic [4*COMP_W-1:0] ram_rdata;

    assign in_xfer   = s_valid && s_ready;
    // A load to a slot beyond the store is dropped.
    assign ram_we    = in_xfer && (s_data.cmd == CMD_LOAD)
                       && (int'(s_data.key_index) < MAX_KEYS);
    assign ram_wdata = {s_data.key_c3, s_data.key_c2, s_data.key_c1, s_data.key_c0};

    cre_ram #(
        .WIDTH (4 * COMP_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (AW'(s_data.key_index)),
        .wdata (ram_wdata),
        .raddr (AW'(idx_reg)),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_data.cmd == CMD_EVAL) begin
                    state_next = ST_PREP;
                    cnt_next   = '0;
                    idx_next   = idx_first;
                end
            end
            ST_PREP: begin
                idx_next = idx_inc;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == PREP_LAST) begin
                    cnt_next   = '0;
                    state_next = orient_reg ? ST_DOT : ST_BLEND;
                end
            end
            ST_DOT: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DOT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == BLEND_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == WAIT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic [F-1:0]           u_reg, u2_reg, u3_reg;
    key_row_t               p_reg [KEY_COMPS];
    logic signed [HW-1:0]   h_reg [KEY_COMPS];
    logic [KEY_COMPS-1:0]   neg_reg;
    comp_t                  res_reg [KEY_COMPS];
    logic                   clip_reg;
    out_item_t              m_data_reg;

    // Shared multiplier operands and the tag of the issued product.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     iss_v, iss_first, iss_last, iss_neg, iss_dot;
    logic [1:0]               iss_grp;
    logic                     v1_reg, first1_reg, last1_reg, neg1_reg, dot1_reg;
    logic [1:0]               grp1_reg;
    logic                     fin_reg, fdot_reg;
    logic [1:0]               fgrp_reg;

    // The multiplier is shared by four kinds of work. While the keys are
    // read it forms u*u and then u2*u. In quaternion mode the dot products
    // of neighboring keys pass through it: rows 0 and 1 always hold the
    // pair, and the rows rotate after each pair. Last come the blend terms,
    // one component at a time over the four keys.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        iss_v     = 1'b0;
        iss_first = 1'b0;
        iss_last  = 1'b0;
        iss_neg   = 1'b0;
        iss_dot   = 1'b0;
        iss_grp   = '0;
        case (state_reg)
            ST_PREP: begin
                if (cnt_reg == CNT_W'(0)) begin
                    mul_a = MUL_W'(u_reg);
                    mul_b = MUL_W'(u_reg);
                end else if (cnt_reg == CNT_W'(2)) begin
                    mul_a = MUL_W'(u2_reg);
                    mul_b = MUL_W'(u_reg);
                end
            end
            ST_DOT: begin
                mul_a     = MUL_W'(p_reg[0][cnt_reg[1:0]]);
                mul_b     = MUL_W'(p_reg[1][cnt_reg[1:0]]);
                iss_v     = 1'b1;
                iss_first = (cnt_reg[1:0] == 2'd0);
                iss_last  = (cnt_reg[1:0] == SUB_LAST);
                iss_dot   = 1'b1;
                iss_grp   = cnt_reg[3:2] + 2'd1;
            end
            ST_BLEND: begin
                mul_a     = MUL_W'(p_reg[cnt_reg[1:0]][cnt_reg[3:2]]);
                mul_b     = MUL_W'(h_reg[cnt_reg[1:0]]);
                iss_v     = 1'b1;
                iss_first = (cnt_reg[1:0] == 2'd0);
                iss_last  = (cnt_reg[1:0] == SUB_LAST);
                iss_neg   = neg_reg[cnt_reg[1:0]];
                iss_grp   = cnt_reg[3:2];
            end
            default: ;
        endcase
    end

    // Rounded square and cube of u, half up.
    logic [PROD_W-1:0] u_rnd_wide;
    logic [F-1:0]      u_rnd;

    assign u_rnd_wide = PROD_W'(prod_reg) + (PROD_W'(1) << (F - 1));
    assign u_rnd      = u_rnd_wide[F +: F];

    // Doubled Catmull-Rom basis weights in units of 2^-F.
    logic signed [HX-1:0] su, s2, s3, two;
    logic signed [HX-1:0] hx [KEY_COMPS];

    always_comb begin
        su    = HX'(u_reg);
        s2    = HX'(u2_reg);
        s3    = HX'(u3_reg);
        two   = HX'(1) <<< (F + 1);
        hx[0] = (s2 <<< 1) - s3 - su;
        hx[1] = (s3 <<< 1) + s3 - ((s2 <<< 2) + s2) + two;
        hx[2] = (s2 <<< 2) + su - ((s3 <<< 1) + s3);
        hx[3] = s3 - s2;
    end

    // Accumulator: the first term of a sum replaces the old value; a term
    // of a sign-flipped key is subtracted.
    logic signed [ACC_W-1:0] acc_reg, acc_base, acc_term, acc_next;

    always_comb begin
        acc_base = first1_reg ? '0 : acc_reg;
        acc_term = ACC_W'(prod_reg);
        acc_next = neg1_reg ? acc_base - acc_term : acc_base + acc_term;
    end

    // Result of a finished sum: round half up, scale down, saturate.
    logic signed [ACC_W-1:0] acc_rnd, acc_shd;
    comp_t                   fin_val;
    logic                    fin_clip;
    logic                    acc_pos, acc_neg;

    always_comb begin
        acc_rnd  = acc_reg + (ACC_W'(1) <<< F);
        acc_shd  = acc_rnd >>> (F + 1);
        fin_clip = 1'b1;
        if (acc_shd > ACC_W'(COMP_MAX)) begin
            fin_val = COMP_W'(COMP_MAX);
        end else if (acc_shd < ACC_W'(COMP_MIN)) begin
            fin_val = COMP_W'(COMP_MIN);
        end else begin
            fin_val  = acc_shd[COMP_W-1:0];
            fin_clip = 1'b0;
        end
        acc_neg = acc_reg[ACC_W-1];
        acc_pos = !acc_reg[ACC_W-1] && (acc_reg != '0);
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= mul_a * mul_b;
        first1_reg <= iss_first;
        last1_reg  <= iss_last;
        neg1_reg   <= iss_neg;
        dot1_reg   <= iss_dot;
        grp1_reg   <= iss_grp;
        fdot_reg   <= dot1_reg;
        fgrp_reg   <= grp1_reg;

        if (v1_reg) begin
            acc_reg <= acc_next;
        end

        if (state_reg == ST_IDLE && in_xfer) begin
            u_reg    <= F'(s_data.frac_u);
            neg_reg  <= '0;
            clip_reg <= 1'b0;
        end

        if (state_reg == ST_PREP) begin
            if (cnt_reg == CNT_W'(1)) begin
                u2_reg <= u_rnd;
            end
            if (cnt_reg == CNT_W'(3)) begin
                u3_reg <= u_rnd;
            end
            if (cnt_reg != CNT_W'(0)) begin
                p_reg[cnt_reg[1:0] - 2'd1] <= ram_rdata;
            end
            if (cnt_reg == PREP_LAST) begin
                for (int i = 0; i < KEY_COMPS; i++) begin
                    h_reg[i] <= HW'(hx[i]);
                end
            end
        end

        // Rotate the key rows after each dot-product pair; after the last
        // pair a double step brings them back into window order.
        if (state_reg == ST_DOT && cnt_reg[1:0] == SUB_LAST) begin
            for (int j = 0; j < KEY_COMPS; j++) begin
                if (cnt_reg == DOT_LAST) begin
                    p_reg[j] <= p_reg[(j + 2) % KEY_COMPS];
                end else begin
                    p_reg[j] <= p_reg[(j + 1) % KEY_COMPS];
                end
            end
        end

        if (fin_reg) begin
            if (fdot_reg) begin
                // The dot is taken with the stored keys, so a flipped
                // predecessor flips the sign test.
                neg_reg[fgrp_reg] <= neg_reg[fgrp_reg - 2'd1] ? acc_pos : acc_neg;
            end else begin
                res_reg[fgrp_reg] <= fin_val;
                clip_reg          <= clip_reg | fin_clip;
            end
        end

        if (out_load) begin
            m_data_reg.out_c0  <= res_reg[0];
            m_data_reg.out_c1  <= res_reg[1];
            m_data_reg.out_c2  <= res_reg[2];
            m_data_reg.out_c3  <= res_reg[3];
            m_data_reg.clipped <= clip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            v1_reg        <= 1'b0;
            fin_reg       <= 1'b0;
            key_count_reg <= KEY_COUNT_RST;
            orient_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
            v1_reg        <= iss_v;
            fin_reg       <= v1_reg && last1_reg;
            key_count_reg <= key_count_next;
            orient_reg    <= orient_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/cre_checker.sv
// ----------------------------------------------------------------------------
// cre_checker: port-level checks of the Catmull-Rom key evaluator
// Watches the channels of the top level over time; bound to every instance.
// ----------------------------------------------------------------------------
module cre_checker
    import cre_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result holds still until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // An evaluate occupies the block, so the next cycle takes no item.
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == CMD_EVAL |=> !s_ready)
        else $error("input taken right after an evaluate transfer");

    // A load is finished in its own cycle.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == CMD_LOAD |=> s_ready)
        else $error("load transfer left the block busy");

    // Results appear only at the end of an evaluate, never out of idle.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the block was idle");

endmodule

bind catmull_rom_key_evaluator cre_checker u_cre_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/cre_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cre_blend_checker: blend predictor and result comparator
// Follows configuration writes and item transfers, keeps its own key store,
// predicts each blended point and compares the result transfers in order.
// ----------------------------------------------------------------------------
module cre_blend_checker
    import cre_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 mismatch_count,
    output int                 blends_pending
);

    localparam int SLOTS        = 16;
    localparam int FRAC         = 16;
    localparam int REPORT_LIMIT = 10;

    comp_t             key_ram [SLOTS][KEY_COMPS];
    logic [KCNT_W-1:0] loop_keys;
    logic              quat_mode;
    out_item_t         blend_queue [$];
    out_item_t         want;
    int                results_seen;

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            for (int c = 0; c < KEY_COMPS; c++) begin
                key_ram[s][c] = '0;
            end
        end
        loop_keys      = KEY_COUNT_RST;
        quat_mode      = 1'b0;
        mismatch_count = 0;
        blends_pending = 0;
        results_seen   = 0;
    end

    // Catmull-Rom blend of the four keys around the segment, at full width.
    function automatic out_item_t blend_keys(input in_item_t it);
        longint    pt [4][KEY_COMPS];
        longint    wt [4];
        longint    u, u2, u3, acc, r, dot;
        int        k, seg, slot, i, c;
        comp_t     res [KEY_COMPS];
        logic      clip;
        out_item_t o;

        k = int'(loop_keys);
        if (k < MIN_KEYS) k = MIN_KEYS;
        if (k > SLOTS) k = SLOTS;
        seg = int'(it.segment) % k;
        for (i = 0; i < 4; i++) begin
            slot = (seg + k - 1 + i) % k;
            for (c = 0; c < KEY_COMPS; c++) begin
                pt[i][c] = key_ram[slot][c];
            end
        end

        // Each later key is flipped onto the hemisphere of the one before it.
        if (quat_mode) begin
            for (i = 1; i < 4; i++) begin
                dot = 0;
                for (c = 0; c < KEY_COMPS; c++) begin
                    dot += pt[i-1][c] * pt[i][c];
                end
                if (dot < 0) begin
                    for (c = 0; c < KEY_COMPS; c++) begin
                        pt[i][c] = -pt[i][c];
                    end
                end
            end
        end

        u  = longint'(it.frac_u);
        u2 = (u * u + (longint'(1) << (FRAC - 1))) >>> FRAC;
        u3 = (u2 * u + (longint'(1) << (FRAC - 1))) >>> FRAC;
        wt[0] = 2 * u2 - u3 - u;
        wt[1] = 3 * u3 - 5 * u2 + (longint'(2) << FRAC);
        wt[2] = 4 * u2 - 3 * u3 + u;
        wt[3] = u3 - u2;

        clip = 1'b0;
        for (c = 0; c < KEY_COMPS; c++) begin
            acc = 0;
            for (i = 0; i < 4; i++) begin
                acc += pt[i][c] * wt[i];
            end
            r = (acc + (longint'(1) << FRAC)) >>> (FRAC + 1);
            if (r > COMP_MAX) begin
                r    = COMP_MAX;
                clip = 1'b1;
            end else if (r < COMP_MIN) begin
                r    = COMP_MIN;
                clip = 1'b1;
            end
            res[c] = comp_t'(r);
        end
        o.out_c0  = res[0];
        o.out_c1  = res[1];
        o.out_c2  = res[2];
        o.out_c3  = res[3];
        o.clipped = clip;
        return o;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            loop_keys = KEY_COUNT_RST;
            quat_mode = 1'b0;
            blend_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_KEY_COUNT: loop_keys = pwdata[KCNT_W-1:0];
                    REG_ORIENT:    quat_mode = pwdata[0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (s_data.cmd == CMD_LOAD) begin
                    key_ram[s_data.key_index][0] = s_data.key_c0;
                    key_ram[s_data.key_index][1] = s_data.key_c1;
                    key_ram[s_data.key_index][2] = s_data.key_c2;
                    key_ram[s_data.key_index][3] = s_data.key_c3;
                end else begin
                    blend_queue.insert(blend_queue.size(), blend_keys(s_data));
                end
            end

            if (m_valid && m_ready) begin
                results_seen++;
                if (blend_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result %0d arrived with no blend pending: %0d %0d %0d %0d clipped %0b",
                                 results_seen, m_data.out_c0, m_data.out_c1,
                                 m_data.out_c2, m_data.out_c3, m_data.clipped);
                    end
                end else begin
                    want = blend_queue.pop_front();
                    if (m_data.out_c0 !== want.out_c0 || m_data.out_c1 !== want.out_c1 ||
                        m_data.out_c2 !== want.out_c2 || m_data.out_c3 !== want.out_c3 ||
                        m_data.clipped !== want.clipped) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("result %0d mismatch: expected %0d %0d %0d %0d clipped %0b",
                                     results_seen, want.out_c0, want.out_c1,
                                     want.out_c2, want.out_c3, want.clipped);
                            $display("    got %0d %0d %0d %0d clipped %0b",
                                     m_data.out_c0, m_data.out_c1, m_data.out_c2,
                                     m_data.out_c3, m_data.clipped);
                        end
                    end
                end
            end
        end
        blends_pending = blend_queue.size();
    end

endmodule

// File: tb/catmull_rom_key_evaluator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_key_evaluator_test: top level of the key evaluator testbench
// Loads keyframes, evaluates points along the closed loop under a series of
// key counts and blend modes, and lets a separate checker judge each result.
// ----------------------------------------------------------------------------
module catmull_rom_key_evaluator_test;
    import cre_pkg::*;

    // An evaluate is slowest in quaternion mode and fits well within this many
    // quiet cycles, so after the last result they mean the block has gone idle.
    localparam int SETTLE_CYCLES = 48;
    // The receiver holds off once for this long so that the output register
    // fills, the next evaluate parks in its last step and s_ready drops.
    localparam int LONG_HOLD     = 400;
    // The longest legitimate quiet stretch is the long hold plus one
    // evaluate; the watchdog allows several times that.
    localparam int IDLE_LIMIT    = 3000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 133;

    localparam comp_t C_MAX = comp_t'(COMP_MAX);
    localparam comp_t C_MIN = comp_t'(COMP_MIN);

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_count;
    int blends_pending;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit hold_request;

    catmull_rom_key_evaluator u_top (.*);

    cre_blend_checker u_checker (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Every item starts from random content in all fields; the fields that its
    // command does not use stay random, so every bit of the payload toggles.
    function automatic in_item_t noise_item();
        in_item_t it;
        it.cmd       = 1'($urandom_range(0, 1));
        it.key_index = IDX_W'($urandom_range(0, 15));
        it.key_c0    = comp_t'($urandom);
        it.key_c1    = comp_t'($urandom);
        it.key_c2    = comp_t'($urandom);
        it.key_c3    = comp_t'($urandom);
        it.segment   = SEG_W'($urandom_range(0, 15));
        it.frac_u    = FRAC_IN_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic in_item_t load_item(input int idx, input comp_t c0, input comp_t c1,
                                           input comp_t c2, input comp_t c3);
        in_item_t it;
        it           = noise_item();
        it.cmd       = CMD_LOAD;
        it.key_index = idx[IDX_W-1:0];
        it.key_c0    = c0;
        it.key_c1    = c1;
        it.key_c2    = c2;
        it.key_c3    = c3;
        return it;
    endfunction

    function automatic in_item_t eval_item(input int seg, input int u);
        in_item_t it;
        it         = noise_item();
        it.cmd     = CMD_EVAL;
        it.segment = seg[SEG_W-1:0];
        it.frac_u  = u[FRAC_IN_W-1:0];
        return it;
    endfunction

    // Components lean toward the rails and toward small values, where
    // saturation and sign alignment are most likely to go wrong.
    function automatic comp_t any_comp();
        case ($urandom_range(0, 9))
            0: return C_MAX;
            1: return C_MIN;
            2, 3: return comp_t'(int'($urandom_range(0, 131072)) - 65536);
            default: return comp_t'($urandom);
        endcase
    endfunction

    // About four items in ten are loads; the rest evaluate at any segment,
    // including segments past the key count, which wrap inside the block.
    function automatic in_item_t random_item();
        int u;
        if ($urandom_range(0, 9) < 4) begin
            return load_item($urandom_range(0, 15), any_comp(), any_comp(),
                             any_comp(), any_comp());
        end
        case ($urandom_range(0, 7))
            0: u = 0;
            1: u = 65535;
            2: u = 32768;
            default: u = $urandom_range(0, 65535);
        endcase
        return eval_item($urandom_range(0, 15), u);
    endfunction

    // The sender works in bursts. At the start of each burst it may leave
    // s_valid low for a few cycles; within a burst it offers items back to
    // back. Valid is raised at a falling edge and held until the rising edge
    // at which s_ready is seen high, which is the transfer.
    task automatic offer(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering, waits for every predicted blend to come back, then
    // gives the sequencer time to finish anything that makes no result.
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (blends_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write: a setup cycle, then an access cycle that completes
    // at the rising edge where pready is high.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] which, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The watchdog counts cycles without any transfer on either channel and
    // ends the run once the block has clearly stopped making progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** catmull_rom_key_evaluator: FAILED **");
            $finish;
        end
    end

    // The receiver keeps its own pattern: stretches of steady acceptance,
    // light or heavy random stalling, and a regular three-in-four rhythm.
    // Once the stimulus asks for it, it holds m_ready low for a long count.
    initial begin : receiver
        int  mode;
        int  span;
        int  n;
        bit  hold_done;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_request && !hold_done) begin
                for (n = 0; n < LONG_HOLD; n++) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
                for (n = 0; n < span; n++) begin
                    @(negedge aclk);
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= ($urandom_range(0, 3) != 0);
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= (n % 4 != 3);
                    endcase
                end
            end
        end
    end

    initial begin : stimulus
        int ph;
        int n;
        int keys;
        int quat;

        // Every input is known from time zero, and reset is held low at the start.
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        hold_request = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. All sixteen slots are written first so that no
        // evaluate can ever read a key that was never loaded. Keys 0 to 3 sit
        // on the rails: blending them overshoots into saturation, and in
        // quaternion mode key 1 is flipped, which negates the most negative
        // component at extended width.
        offer(load_item(0, C_MIN, C_MAX, C_MIN, '0));
        offer(load_item(1, C_MAX, C_MIN, C_MAX, C_MAX));
        offer(load_item(2, C_MAX, C_MIN, C_MAX, C_MAX));
        offer(load_item(3, C_MIN, C_MAX, C_MIN, '0));
        for (n = 4; n < 16; n++) begin
            offer(load_item(n, comp_t'(n * 70000 - 500000), comp_t'(-n * 33000),
                            comp_t'(n * n * 4096), comp_t'(65536 - n * 9000)));
        end

        // Reset settings: four keys, position mode. The fraction runs over
        // zero, one half, its largest value and one step; segment 15 wraps.
        offer(eval_item(0, 0));
        offer(eval_item(1, 32768));
        offer(eval_item(3, 65535));
        offer(eval_item(15, 1));
        offer(eval_item(2, 32768));

        // Same keys with sign alignment on.
        quiesce();
        cfg_write(REG_ORIENT, 1);
        offer(eval_item(1, 32768));
        offer(eval_item(0, 65535));
        offer(eval_item(2, 0));

        // Random part. Each phase sets both registers while the block is idle,
        // covering the smallest and largest loops, odd sizes in between, and
        // counts below four and above sixteen that the block clamps.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin keys = 16; quat = 1; end
                1: begin keys = 7;  quat = 0; end
                2: begin keys = 0;  quat = 1; end
                3: begin keys = 31; quat = 0; end
                4: begin keys = 16; quat = 0; end
                5: begin keys = 10; quat = 1; end
                6: begin keys = 4;  quat = 0; end
                7: begin keys = 2;  quat = 1; end
                8: begin keys = 20; quat = 0; end
                default: begin keys = 4; quat = 1; end
            endcase
            quiesce();
            cfg_write(REG_KEY_COUNT, keys);
            cfg_write(REG_ORIENT, quat);
            // The long receiver hold lands in the slowest setting, while the
            // sender keeps pushing items into the full block.
            if (ph == 0) hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                offer(random_item());
            end
        end

        quiesce();
        if (mismatch_count == 0 && blends_pending == 0) begin
            $display("** catmull_rom_key_evaluator: PASSED **");
        end else begin
            $display("** catmull_rom_key_evaluator: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
sv/cre_pkg.sv
sv/cre_ram.sv
sv/catmull_rom_key_evaluator.sv
sv/cre_checker.sv
tb/cre_blend_checker.sv
tb/catmull_rom_key_evaluator_test.sv
